// ===== rtl/core/mat_pkg.sv =====
// Package for the moving average trend block: result field widths,
// fixed-point constants and tuser bit positions.
// No dependencies.
`timescale 1ns / 1ps

package mat_pkg;

  // Result field widths and packing
  localparam int AVG_W       = 28;
  localparam int PCT_W       = 32;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 3;

  // Fixed-point scaling
  localparam int AVG_FRAC_BITS = 8;
  localparam int HUNDRED_Q8_W  = 15;
  localparam logic [HUNDRED_Q8_W-1:0] HUNDRED_Q8 = HUNDRED_Q8_W'(25600);

  // Saturation limits
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_MAX = {1'b0, {(PCT_W-1){1'b1}}};

  // Bit positions in the result tuser
  localparam int USR_AVG_VALID   = 0;
  localparam int USR_CHG_VALID   = 1;
  localparam int USR_CHG_UNDEF   = 2;

endpackage : mat_pkg

// ===== rtl/core/mat_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Standalone; used by the moving average trend top level.
`timescale 1ns / 1ps

module mat_divider #(
  parameter int DIVIDEND_W = 38,
  parameter int DIVISOR_W  = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;

  // Trial subtraction for the current bit
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  // Control: count down one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : mat_divider

// ===== rtl/core/moving_average_trend.sv =====
// Moving average trend: the ratio divider, which retires one quotient bit per cycle,
// sets when a result appears; the average comes from a registered reciprocal multiply
// in the meantime. One transaction is in work at a time: the next is accepted once the
// last result has been loaded into the output register, later while that register
// still holds an unaccepted result.
// Synchronous active-low reset clears control state and holds in_tready low; the
// memories need no clearing pass (a fill count masks entries not yet written).
// Depends on mat_pkg and mat_divider.
`timescale 1ns / 1ps

module moving_average_trend
  import mat_pkg::*;
#(
  parameter int WINDOW_LEN  = 7,
  parameter int CHANGE_SPAN = 14,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: daily_count [SAMPLE_BITS-1:0], zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // tuser: series_start [0]
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: window_average [27:0], change_percent [59:28], zero padding above
  output logic [OUT_DATA_W-1:0]               out_tdata,
  // tuser: average_valid [0], change_valid [1], change_undefined [2]
  output logic [OUT_USER_W-1:0]               out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready
);

  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int HIST_LEN = CHANGE_SPAN - 1;
  localparam int LINE_AW  = $clog2(WINDOW_LEN);
  localparam int HIST_AW  = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int SEEN_MAX = WINDOW_LEN + CHANGE_SPAN - 1;
  localparam int SEEN_W   = $clog2(SEEN_MAX + 1);
  localparam int AVG_N    = SUM_W + AVG_FRAC_BITS;
  localparam int PROD_W   = SUM_W + 7;
  localparam int RATIO_N  = SUM_W + HUNDRED_Q8_W;

  // Reciprocal of the window length, exact for every dividend below 2^AVG_N
  localparam int RECIP_K   = AVG_N + $clog2(WINDOW_LEN);
  localparam int AVG_SHIFT = RECIP_K - AVG_FRAC_BITS;
  localparam int AVG_PW    = AVG_SHIFT + AVG_N;
  localparam logic [63:0] RECIP_NUM = (64'd1 << RECIP_K) + 64'(WINDOW_LEN - 1);
  localparam logic [AVG_PW-1:0] RECIP_M = AVG_PW'(RECIP_NUM / 64'(WINDOW_LEN));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SEEN_W-1:0]      seen_r;
  logic [LINE_AW-1:0]     line_slot_r;
  logic [HIST_AW-1:0]     hist_slot_r;

  logic [SAMPLE_BITS-1:0] line_mem [WINDOW_LEN];
  logic [SUM_W-1:0]       hist_mem [HIST_LEN];
  logic [SAMPLE_BITS-1:0] line_rd_r;
  logic [SUM_W-1:0]       hist_rd_r;

  logic                   in_acc;
  logic                   rd_en;
  logic [LINE_AW-1:0]     line_rd_addr;
  logic [HIST_AW-1:0]     hist_rd_addr;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_upd;
  logic [SEEN_W-1:0]      seen_upd;
  logic                   avg_ok;
  logic                   chg_ok;
  logic                   div_start;
  logic [PROD_W-1:0]      prod;
  logic [AVG_PW-1:0]      avg_prod_r;
  logic                   ratio_done;
  logic [AVG_N-1:0]       avg_q;
  logic [RATIO_N-1:0]     ratio_q;
  logic                   out_load;

  logic [63:0]            avg_q64, ratio_q64, diff64;
  logic [AVG_W-1:0]       avg_res;
  logic [PCT_W-1:0]       pct_res;
  logic                   undef_res;

  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic [OUT_USER_W-1:0]  out_tuser_r;
  logic                   out_tvalid_r;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_en     = in_acc;
  assign avg_ok    = (seen_r >= SEEN_W'(WINDOW_LEN));
  assign chg_ok    = (seen_r >= SEEN_W'(SEEN_MAX));
  assign div_start = (state_r == ST_LOAD);
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Read addresses: a series start restarts both rings at slot zero
  assign line_rd_addr = in_tuser ? '0 : line_slot_r;
  assign hist_rd_addr = in_tuser ? '0 : hist_slot_r;

  // Sample leaving the window reads as zero until the window has filled
  always_comb begin
    old_sample = (seen_r < SEEN_W'(WINDOW_LEN)) ? '0 : line_rd_r;
    sum_upd    = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
    seen_upd   = (seen_r < SEEN_W'(SEEN_MAX)) ? seen_r + SEEN_W'(1) : seen_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (ratio_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and series bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      seen_r      <= '0;
      line_slot_r <= '0;
      hist_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser) begin
        sum_r       <= '0;
        seen_r      <= '0;
        line_slot_r <= '0;
        hist_slot_r <= '0;
      end
      if (state_r == ST_READ) begin
        sum_r       <= sum_upd;
        seen_r      <= seen_upd;
        line_slot_r <= (line_slot_r == LINE_AW'(WINDOW_LEN - 1)) ?
                       '0 : line_slot_r + LINE_AW'(1);
      end
      if (state_r == ST_LOAD && avg_ok) begin
        hist_slot_r <= (hist_slot_r == HIST_AW'(HIST_LEN - 1)) ?
                       '0 : hist_slot_r + HIST_AW'(1);
      end
    end
  end

  // Hold the accepted sample
  always_ff @(posedge clk) begin
    if (in_acc) sample_r <= in_tdata[SAMPLE_BITS-1:0];
  end

  // Sample ring: read on acceptance, write back the new sample
  always_ff @(posedge clk) begin
    if (rd_en) line_rd_r <= line_mem[line_rd_addr];
    if (state_r == ST_READ) line_mem[line_slot_r] <= sample_r;
  end

  // Window sum history: read on acceptance, write the new sum once averaged
  always_ff @(posedge clk) begin
    if (rd_en) hist_rd_r <= hist_mem[hist_rd_addr];
    if (state_r == ST_LOAD && avg_ok) hist_mem[hist_slot_r] <= sum_r;
  end

  // Sum times one hundred by shift and add
  assign prod = PROD_W'({sum_r, 6'b0}) + PROD_W'({sum_r, 5'b0}) + PROD_W'({sum_r, 2'b0});

  // Average: sum times 256 over the window length by reciprocal multiply
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) avg_prod_r <= AVG_PW'(sum_r) * RECIP_M;
  end

  assign avg_q = avg_prod_r[AVG_SHIFT +: AVG_N];

  mat_divider #(
    .DIVIDEND_W (RATIO_N),
    .DIVISOR_W  (SUM_W)
  ) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({prod, 8'b0}),
    .divisor  (hist_rd_r),
    .done     (ratio_done),
    .quotient (ratio_q)
  );

  // Saturate the average and form the signed percent change
  always_comb begin
    avg_q64   = 64'(avg_q);
    ratio_q64 = 64'(ratio_q);
    diff64    = ratio_q64 - 64'(HUNDRED_Q8);
    avg_res   = '0;
    pct_res   = '0;
    undef_res = 1'b0;
    if (avg_ok) begin
      avg_res = (avg_q64 > 64'(AVG_MAX)) ? AVG_MAX : avg_q64[AVG_W-1:0];
    end
    if (chg_ok) begin
      if (hist_rd_r == '0) begin
        undef_res = 1'b1;
      end else if (ratio_q64 >= 64'(HUNDRED_Q8)) begin
        pct_res = (diff64 > 64'(PCT_MAX)) ? PCT_MAX : diff64[PCT_W-1:0];
      end else begin
        pct_res = PCT_W'(ratio_q64[PCT_W-1:0]) - PCT_W'(HUNDRED_Q8);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r                 <= OUT_DATA_W'({pct_res, avg_res});
      out_tuser_r[USR_AVG_VALID]  <= avg_ok;
      out_tuser_r[USR_CHG_VALID]  <= chg_ok;
      out_tuser_r[USR_CHG_UNDEF]  <= undef_res;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_tvalid_r;

  // An accepted transaction always moves on to the memory read
  a_acc_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_READ))
    else $error("accepted transaction did not advance to read");

  // A change is only ever reported alongside an average
  a_chg_needs_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[USR_CHG_VALID] || out_tuser[USR_AVG_VALID]))
    else $error("change reported without an average");

  // An undefined change carries a valid flag and a zero percent
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[USR_CHG_UNDEF]) |->
      (out_tuser[USR_CHG_VALID] && out_tdata[AVG_W+:PCT_W] == '0))
    else $error("undefined change with non-zero percent");

  // Fill count never passes its saturation point
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_W'(SEEN_MAX))
    else $error("sample count beyond saturation");

  // A new result only appears on leaving the final state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the final state");

endmodule : moving_average_trend

// ===== tb/sv/tb.sv =====
// Testbench for moving_average_trend: drives daily samples over the stream input,
// predicts each window average and period change, and checks every result.
// Depends on mat_pkg and the moving_average_trend RTL.
`timescale 1ns / 1ps

// Running model of the trend block: keeps its own sample window and sum history,
// and holds the expected result for every accepted sample until it comes out.
class trend_scoreboard;
  localparam int WIN       = 7;
  localparam int SPAN      = 14;
  localparam int HIST      = SPAN - 1;
  localparam int SEEN_MAX  = WIN + SPAN - 1;
  localparam int SAMPLE_W  = 20;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic                     avg_ok;
    logic [mat_pkg::AVG_W-1:0] avg;
    logic                     chg_ok;
    logic [mat_pkg::PCT_W-1:0] pct;
    logic                     undef;
  } trend_t;

  bit [SAMPLE_W-1:0] day_samples[WIN];
  bit [63:0]         window_total;
  bit [63:0]         past_totals[HIST];
  int                days_seen;
  int                day_pos;
  int                past_pos;

  trend_t pending_trends[$];
  int     mismatches;
  int     results_checked;
  int     n_change;
  int     n_undef;
  int     n_sat;
  int     n_neg;

  function new();
    clear_series();
  endfunction

  function void clear_series();
    foreach (day_samples[i]) day_samples[i] = '0;
    foreach (past_totals[i]) past_totals[i] = '0;
    window_total = '0;
    days_seen    = 0;
    day_pos      = 0;
    past_pos     = 0;
  endfunction

  // Advance the window by one sample and work out the result it causes
  function trend_t predict_trend(bit [SAMPLE_W-1:0] sample, bit start);
    trend_t    r;
    bit [63:0] avg_full;
    bit [63:0] old_total;
    bit [63:0] ratio;
    bit [63:0] rise;
    bit [63:0] hundred;
    hundred = 64'(mat_pkg::HUNDRED_Q8);
    r = '0;
    if (start) clear_series();
    window_total = window_total - day_samples[day_pos] + sample;
    day_samples[day_pos] = sample;
    day_pos = (day_pos + 1) % WIN;
    if (days_seen < SEEN_MAX) days_seen++;
    if (days_seen >= WIN) begin
      r.avg_ok = 1'b1;
      avg_full = (window_total * 256) / WIN;
      if (avg_full > 64'(mat_pkg::AVG_MAX)) avg_full = 64'(mat_pkg::AVG_MAX);
      r.avg = avg_full[mat_pkg::AVG_W-1:0];
      // compare against the window sum from span - 1 days back
      if (days_seen >= SEEN_MAX) begin
        old_total = past_totals[past_pos];
        r.chg_ok  = 1'b1;
        if (old_total == 0) begin
          r.undef = 1'b1;
        end else begin
          ratio = (window_total * hundred) / old_total;
          if (ratio >= hundred) begin
            rise = ratio - hundred;
            if (rise > 64'(mat_pkg::PCT_MAX)) begin
              r.pct = mat_pkg::PCT_MAX;
            end else begin
              r.pct = rise[mat_pkg::PCT_W-1:0];
            end
          end else begin
            r.pct = 32'(0) - 32'(hundred - ratio);
          end
        end
      end
      past_totals[past_pos] = window_total;
      past_pos = (past_pos + 1) % HIST;
    end
    return r;
  endfunction

  function void note_sample(bit [SAMPLE_W-1:0] sample, bit start);
    trend_t r;
    r = predict_trend(sample, start);
    if (r.chg_ok) n_change++;
    if (r.undef) n_undef++;
    if (r.chg_ok && r.pct == mat_pkg::PCT_MAX) n_sat++;
    if (r.pct[mat_pkg::PCT_W-1]) n_neg++;
    pending_trends.push_back(r);
  endfunction

  task report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               $realtime, what, results_checked, got, want);
  endtask

  // Compare one transaction from the result channel with the oldest expectation
  task check_result(logic [mat_pkg::OUT_DATA_W-1:0] tdata,
                    logic [mat_pkg::OUT_USER_W-1:0] tuser);
    trend_t want;
    trend_t got;
    if (pending_trends.size() == 0) begin
      report_mismatch("unexpected result", tdata, 0);
    end else begin
      want       = pending_trends.pop_front();
      got.avg_ok = tuser[mat_pkg::USR_AVG_VALID];
      got.chg_ok = tuser[mat_pkg::USR_CHG_VALID];
      got.undef  = tuser[mat_pkg::USR_CHG_UNDEF];
      got.avg    = tdata[0 +: mat_pkg::AVG_W];
      got.pct    = tdata[mat_pkg::AVG_W +: mat_pkg::PCT_W];
      if (got.avg_ok !== want.avg_ok) report_mismatch("average_valid", got.avg_ok, want.avg_ok);
      if (got.avg !== want.avg) report_mismatch("window_average", got.avg, want.avg);
      if (got.chg_ok !== want.chg_ok) report_mismatch("change_valid", got.chg_ok, want.chg_ok);
      if (got.pct !== want.pct) report_mismatch("change_percent", got.pct, want.pct);
      if (got.undef !== want.undef)
        report_mismatch("change_undefined", got.undef, want.undef);
    end
    results_checked++;
  endtask
endclass

module tb;
  import mat_pkg::*;

  localparam int SAMPLE_W   = 20;
  localparam int IN_W       = ((SAMPLE_W + 7) / 8) * 8;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 320;

  // Content shapes for a random series
  typedef enum int {
    FILL_FULL,
    FILL_SPARSE,
    FILL_STEADY,
    FILL_TINY
  } fill_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int samples_sent = 0;
  int series_sent = 0;
  int quiet_cycles = 0;

  trend_scoreboard trend_sb = new();

  moving_average_trend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #2 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) trend_sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample, idling first at random, and hold it until accepted
  task send_sample(input logic [IN_W-1:0] data, input logic start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= data;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    trend_sb.note_sample(data[SAMPLE_W-1:0], start);
    samples_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (trend_sb.pending_trends.size() != 0) @(posedge clk);
  endtask

  // One series: a start flag, then samples of one shape; some series break early
  // and a few carry a stray start flag in the middle
  task send_random_series();
    fill_mode_t      mode;
    int              len;
    int unsigned     base;
    int unsigned     sample;
    logic [IN_W-1:0] word;
    logic            start;
    mode = fill_mode_t'($urandom_range(0, 3));
    len  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 19) : $urandom_range(20, 45);
    base = $urandom_range(1, SAMPLE_MAX);
    series_sent++;
    for (int i = 0; i < len; i++) begin
      case (mode)
        FILL_FULL: begin
          sample = $urandom_range(0, SAMPLE_MAX);
        end
        FILL_SPARSE: begin
          sample = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(0, SAMPLE_MAX);
        end
        FILL_STEADY: begin
          sample = base - base / 8 + $urandom_range(0, base / 4);
          if (sample > SAMPLE_MAX) sample = SAMPLE_MAX;
        end
        default: begin
          sample = $urandom_range(0, 1);
        end
      endcase
      start = (i == 0) || ($urandom_range(0, 99) < 2);
      word  = {4'($urandom_range(0, 15)), sample[SAMPLE_W-1:0]};
      send_sample(word, start);
    end
  endtask

  // Stimulus
  initial begin
    int phase_send[4];
    int phase_recv[4];
    int goal;
    phase_send = '{0, 75, 0, 20};
    phase_recv = '{0, 0, 75, 20};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed series: a single one, zero windows, then full-scale samples so
    // that the change saturates and the average reaches its largest value;
    // the garbage above the sample field must be ignored
    series_sent++;
    send_sample({4'hF, 20'd1}, 1'b1);
    for (int i = 0; i < 12; i++) send_sample({4'hA, 20'd0}, 1'b0);
    for (int i = 0; i < 7; i++) send_sample({4'h0, 20'hFFFFF}, 1'b0);
    // older sum zero: change undefined
    send_sample({4'h5, 20'd0}, 1'b0);
    send_sample({4'h0, 20'd0}, 1'b0);
    // start flag on a busy series clears it
    series_sent++;
    send_sample({4'hF, 20'hFFFFF}, 1'b1);
    send_sample({4'h0, 20'h55555}, 1'b0);
    drain_results();

    // Random phases with different idling, draining in between
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      goal = samples_sent + PHASE_ITEMS;
      while (samples_sent < goal) send_random_series();
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trend_sb.pending_trends.size() != 0)
      trend_sb.report_mismatch("results never returned", trend_sb.pending_trends.size(), 0);

    $display("covered %0d samples in %0d series, %0d results checked", samples_sent,
             series_sent, trend_sb.results_checked);
    $display("changes %0d, undefined %0d, saturated %0d, negative %0d, mismatches %0d",
             trend_sb.n_change, trend_sb.n_undef, trend_sb.n_sat, trend_sb.n_neg,
             trend_sb.mismatches);
    if (trend_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
